/* rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the palette packer blocks.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define PALT_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PALT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/palt_pkg.sv */
// ------------------------------------------------------------------------
// palt_pkg
// Shared types and codes of the palette to truecolor packer.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package palt_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_PIXEL   = 2'd0;
    localparam logic [1:0] CMD_PALETTE = 2'd1;
    localparam logic [1:0] CMD_FRAME   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;  // unknown, dropped

    // Pixel formats
    localparam logic [1:0] FMT_TWO   = 2'd0;
    localparam logic [1:0] FMT_THREE = 2'd1;
    localparam logic [1:0] FMT_FOUR  = 2'd2;
    localparam logic [1:0] FMT_NONE  = 2'd3;    // unknown, pixels dropped

    // Register indexes
    localparam logic [2:0] REG_PIXEL_FORMAT   = 3'd0;
    localparam logic [2:0] REG_RGB_ORDER      = 3'd1;
    localparam logic [2:0] REG_MSB_FIRST      = 3'd2;
    localparam logic [2:0] REG_ROW_WIDTH      = 3'd3;
    localparam logic [2:0] REG_PAD_ENABLE     = 3'd4;
    localparam logic [2:0] REG_PAD_UNIT       = 3'd5;
    localparam logic [2:0] REG_CHANNEL_SHIFTS = 3'd6;
    localparam logic [2:0] REG_CHANNEL_MASKS  = 3'd7;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic        rgb_order_rgb;
        logic        msb_first;
        logic [12:0] row_width;
        logic        pad_enable;
        logic [2:0]  pad_unit_bytes;
        logic [15:0] channel_shifts;
        logic [31:0] channel_masks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pixel_format:   FMT_FOUR,
        rgb_order_rgb:  1'b1,
        msb_first:      1'b0,
        row_width:      13'd1,
        pad_enable:     1'b0,
        pad_unit_bytes: 3'd4,
        channel_shifts: 16'd0,
        channel_masks:  32'd0
    };

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } color_t;

endpackage

/* rtl/palette_truecolor_packer.sv */
// ------------------------------------------------------------------------
// palette_truecolor_packer
// Indexed-colour pixels in, truecolor frame buffer byte writes out.
// ------------------------------------------------------------------------
// Load the palette with palette-write words, send a frame-start word, then
// send pixel words in raster order; each pixel comes out as byte writes
// (address, value), two in two-byte mode and three in three- and four-byte
// modes, the last one flagged with m_tlast. Palette writes, frame starts and
// ignored words give no output. Sustained rate is set by the back end,
// which drives one output word per cycle while m_tready is high. The
// front end takes a word every cycle as long as the 4-deep job queue
// has room, so palette writes and frame starts overlap output of earlier
// pixels. A pixel word passes the palette read stage, the job queue and
// the current-pixel register before its first byte write is registered
// onto m_tvalid. The palette is a RAM with registered read and is
// undefined until written; it needs no clearing after reset.
// Configuration may only be changed while the block is idle; cfg_ready is
// always high.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_truecolor_packer
    import palt_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int ADDRESS_BITS  = 25
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,

    // configuration write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [2:0]                              cfg_index,
    input  logic [31:0]                             cfg_data,

    // input words
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // pixel_index[7:0], palette_index[15:8], color_red[31:16],
    // color_green[47:32], color_blue[63:48]
    input  logic [63:0]                             s_tdata,
    // command[1:0]
    input  logic [1:0]                              s_tuser,

    // byte writes out
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // byte_address[ADDRESS_BITS-1:0], byte_value above it, zero fill
    output logic [((ADDRESS_BITS+8+7)/8)*8-1:0]     m_tdata,
    output logic                                    m_tlast
);

    localparam int AW  = ADDRESS_BITS;
    localparam int QW  = AW + 2 + $bits(color_t);
    localparam int LW  = $clog2(QUEUE_DEPTH+1);
    localparam int TDW = ((ADDRESS_BITS+8+7)/8)*8;

    cfg_t            cfg_reg, cfg_next;
    color_t          in_color;

    logic            push;
    logic [QW-1:0]   push_data;
    logic            pop;
    logic            head_valid;
    logic [QW-1:0]   head_data;
    logic [LW-1:0]   queue_level;

    logic [AW-1:0]   byte_address;
    logic [7:0]      byte_value;

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT:   cfg_next.pixel_format   = cfg_data[1:0];
                REG_RGB_ORDER:      cfg_next.rgb_order_rgb  = cfg_data[0];
                REG_MSB_FIRST:      cfg_next.msb_first      = cfg_data[0];
                REG_ROW_WIDTH:      cfg_next.row_width      = cfg_data[12:0];
                REG_PAD_ENABLE:     cfg_next.pad_enable     = cfg_data[0];
                REG_PAD_UNIT:       cfg_next.pad_unit_bytes = cfg_data[2:0];
                REG_CHANNEL_SHIFTS: cfg_next.channel_shifts = cfg_data[15:0];
                REG_CHANNEL_MASKS:  cfg_next.channel_masks  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- front: accept, palette, position ----------------
    assign in_color.red   = s_tdata[31:16];
    assign in_color.green = s_tdata[47:32];
    assign in_color.blue  = s_tdata[63:48];

    palt_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .pixel_index   (s_tdata[7:0]),
        .palette_index (s_tdata[15:8]),
        .palette_color (in_color),
        .queue_level   (queue_level),
        .push          (push),
        .push_data     (push_data)
    );

    // ---------------- job queue ----------------
    palt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .level      (queue_level)
    );

    // ---------------- back: byte writes ----------------
    palt_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .m_tlast      (m_tlast)
    );

    assign m_tdata = TDW'({byte_value, byte_address});

endmodule

/* rtl/palt_queue.sv */
// ------------------------------------------------------------------------
// palt_queue
// Small show-ahead FIFO between the front and the back end.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palt_queue
    import palt_pkg::*;
#(
    parameter int WIDTH = 75,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       head_valid,
    output logic [WIDTH-1:0]           head_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (level_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

    `PALT_NEVER(a_no_overflow, aclk, aresetn, push && !pop && (level_reg == LW'(DEPTH)), "queue overflow")
    `PALT_NEVER(a_no_underflow, aclk, aresetn, pop && (level_reg == '0), "queue underflow")
    `PALT_ASSERT(a_push_fills, aclk, aresetn, (push && !pop) |=> (level_reg != '0), "queue lost a word")

endmodule

/* rtl/palt_front.sv */
// ------------------------------------------------------------------------
// palt_front
// Accepts input words, keeps the palette and the frame position, and
// queues one pixel job (address, format, colour) per accepted pixel in a known format.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module palt_front
    import palt_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int ADDRESS_BITS  = 25
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cfg_t                                  cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [1:0]                            s_tuser,
    input  logic [7:0]                            pixel_index,
    input  logic [7:0]                            palette_index,
    input  color_t                                palette_color,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      queue_level,
    output logic                                  push,
    output logic [ADDRESS_BITS+2+$bits(color_t)-1:0] push_data
);

    localparam int AW  = ADDRESS_BITS;
    localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int WW  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH+1) : 1;
    localparam int LW  = $clog2(QUEUE_DEPTH+1);

    color_t         palette_mem [PALETTE_DEPTH];
    color_t         rd_data_reg;

    logic           s1_valid_reg, s1_valid_next;
    logic [AW-1:0]  s1_addr_reg;
    logic [1:0]     s1_fmt_reg;
    logic           s1_zero_reg;

    logic [WW-1:0]  column_reg, column_next;
    logic [AW-1:0]  row_base_reg, row_base_next;
    logic [AW-1:0]  pixel_addr_reg, pixel_addr_next;

    logic           accept;
    logic           pixel_go;
    logic           pal_wr;
    logic [WW-1:0]  width_eff;
    logic [AW-1:0]  width_a;
    logic [AW-1:0]  bpp;
    logic [AW-1:0]  stride;
    logic [2:0]     pad;
    logic [1:0]     rem3;
    logic [WW:0]    column_inc;
    logic           row_end;
    color_t         color_out;

    // keep one slot free for the job in the read stage
    assign s_tready = ((LW+1)'(queue_level) + (LW+1)'(s1_valid_reg)) < (LW+1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign pixel_go = accept && (s_tuser == CMD_PIXEL) && (cfg.pixel_format != FMT_NONE);
    assign pal_wr   = accept && (s_tuser == CMD_PALETTE)
                      && (9'(palette_index) < 9'(PALETTE_DEPTH));

    // width clamp: zero reads as one, large values saturate
    always_comb begin
        if (cfg.row_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(cfg.row_width) > 32'(MAX_ROW_WIDTH)) begin
            width_eff = WW'(MAX_ROW_WIDTH);
        end else begin
            width_eff = WW'(cfg.row_width);
        end
    end

    assign width_a = AW'(width_eff);
    assign rem3    = width_eff[0 +: 1] == 1'b1 ?
                     2'(2'(width_eff) + 2'(width_eff << 1)) :
                     2'(2'(width_eff) + 2'(width_eff << 1));

    always_comb begin
        bpp    = AW'(4);
        stride = width_a << 2;
        pad    = '0;
        case (cfg.pixel_format)
            FMT_TWO: begin
                bpp    = AW'(2);
                stride = width_a << 1;
                if (cfg.pad_enable && width_eff[0]) begin
                    pad = 3'd2;
                end
            end
            FMT_THREE: begin
                bpp    = AW'(3);
                stride = (width_a << 1) + width_a;
                if (cfg.pad_enable && (rem3 != 2'd0) && (cfg.pad_unit_bytes > 3'(rem3))) begin
                    pad = cfg.pad_unit_bytes - 3'(rem3);
                end
            end
            default: begin
                bpp    = AW'(4);
                stride = width_a << 2;
            end
        endcase
    end

    assign column_inc = (WW+1)'(column_reg) + (WW+1)'(1);
    assign row_end    = column_inc >= (WW+1)'(width_eff);

    always_comb begin
        column_next     = column_reg;
        row_base_next   = row_base_reg;
        pixel_addr_next = pixel_addr_reg;
        s1_valid_next   = pixel_go;
        if (accept && (s_tuser == CMD_FRAME)) begin
            column_next     = '0;
            row_base_next   = '0;
            pixel_addr_next = '0;
        end else if (pixel_go) begin
            if (row_end) begin
                column_next     = '0;
                row_base_next   = row_base_reg + stride + AW'(pad);
                pixel_addr_next = row_base_reg + stride + AW'(pad);
            end else begin
                column_next     = column_inc[WW-1:0];
                pixel_addr_next = pixel_addr_reg + bpp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            row_base_reg   <= '0;
            pixel_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end else begin
            column_reg     <= column_next;
            row_base_reg   <= row_base_next;
            pixel_addr_reg <= pixel_addr_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pixel_go) begin
            s1_addr_reg <= pixel_addr_reg;
            s1_fmt_reg  <= cfg.pixel_format;
            s1_zero_reg <= !(9'(pixel_index) < 9'(PALETTE_DEPTH));
        end
    end

    // palette RAM, registered read
    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            palette_mem[palette_index[PAW-1:0]] <= palette_color;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= palette_mem[pixel_index[PAW-1:0]];
    end

    assign color_out = s1_zero_reg ? color_t'('0) : rd_data_reg;
    assign push      = s1_valid_reg;
    assign push_data = {color_out, s1_fmt_reg, s1_addr_reg};

endmodule

/* rtl/palt_back.sv */
// ------------------------------------------------------------------------
// palt_back
// Takes pixel jobs from the queue and emits one byte write per cycle,
// while m_tready allows, through a registered output stage.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palt_back
    import palt_pkg::*;
#(
    parameter int ADDRESS_BITS = 25
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  cfg_t                                     cfg,
    input  logic                                     head_valid,
    input  logic [ADDRESS_BITS+2+$bits(color_t)-1:0] head_data,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [ADDRESS_BITS-1:0]                  byte_address,
    output logic [7:0]                               byte_value,
    output logic                                     m_tlast
);

    localparam int AW = ADDRESS_BITS;

    logic            cur_valid_reg, cur_valid_next;
    logic [1:0]      step_reg, step_next;
    logic [AW-1:0]   cur_addr_reg;
    logic [1:0]      cur_fmt_reg;
    color_t          cur_color_reg;

    logic            out_valid_reg;
    logic [AW-1:0]   out_addr_reg;
    logic [7:0]      out_value_reg;
    logic            out_last_reg;

    logic            load_out;
    logic            emit;
    logic            is_last;
    logic [1:0]      off_r, off_g, off_b, off;
    logic [7:0]      value;
    logic [AW-1:0]   head_addr;
    logic [1:0]      head_fmt;
    color_t          head_color;

    function automatic logic [7:0] part16(input logic [15:0] chan,
                                          input logic [3:0]  sh,
                                          input logic [7:0]  mk);
        logic [15:0] shifted;
        begin
            shifted = chan >> sh;
            part16  = shifted[7:0] & mk;
        end
    endfunction

    assign head_addr  = head_data[AW-1:0];
    assign head_fmt   = head_data[AW+1:AW];
    assign head_color = head_data[AW+2 +: $bits(color_t)];

    assign load_out = !out_valid_reg || m_tready;
    assign emit     = cur_valid_reg && load_out;
    assign is_last  = (cur_fmt_reg == FMT_TWO) ? (step_reg == 2'd1) : (step_reg == 2'd2);
    assign pop      = head_valid && (!cur_valid_reg || (emit && is_last));

    always_comb begin
        off_r = cfg.rgb_order_rgb ? 2'd2 : 2'd0;
        off_g = 2'd1;
        off_b = cfg.rgb_order_rgb ? 2'd0 : 2'd2;
        if ((cur_fmt_reg == FMT_FOUR) && cfg.msb_first) begin
            off_r = off_r + 2'd1;
            off_g = off_g + 2'd1;
            off_b = off_b + 2'd1;
        end
    end

    always_comb begin
        off   = '0;
        value = '0;
        if (cur_fmt_reg == FMT_TWO) begin
            if (step_reg == 2'd0) begin
                off   = 2'd0;
                value = part16(cur_color_reg.blue, cfg.channel_shifts[3:0],
                               cfg.channel_masks[7:0])
                      + part16(cur_color_reg.green, cfg.channel_shifts[11:8],
                               cfg.channel_masks[23:16]);
            end else begin
                off   = 2'd1;
                value = part16(cur_color_reg.green, cfg.channel_shifts[7:4],
                               cfg.channel_masks[15:8])
                      + part16(cur_color_reg.red, cfg.channel_shifts[15:12],
                               cfg.channel_masks[31:24]);
            end
        end else begin
            case (step_reg)
                2'd0: begin
                    off   = off_b;
                    value = cur_color_reg.blue[15:8];
                end
                2'd1: begin
                    off   = off_g;
                    value = cur_color_reg.green[15:8];
                end
                default: begin
                    off   = off_r;
                    value = cur_color_reg.red[15:8];
                end
            endcase
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            step_next      = '0;
        end else if (emit) begin
            if (is_last) begin
                cur_valid_next = 1'b0;
                step_next      = '0;
            end else begin
                step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            if (load_out) begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_addr_reg  <= head_addr;
            cur_fmt_reg   <= head_fmt;
            cur_color_reg <= head_color;
        end
        if (emit) begin
            out_addr_reg  <= cur_addr_reg + AW'(off);
            out_value_reg <= value;
            out_last_reg  <= is_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign byte_address = out_addr_reg;
    assign byte_value   = out_value_reg;
    assign m_tlast      = out_last_reg;

    `PALT_NEVER(a_pop_needs_head, aclk, aresetn, pop && !head_valid, "pop from empty queue")
    `PALT_NEVER(a_two_byte_steps, aclk, aresetn, cur_valid_reg && (cur_fmt_reg == FMT_TWO) && (step_reg > 2'd1), "two-byte pixel ran past its second word")
    `PALT_ASSERT(a_step_restart, aclk, aresetn, (emit && is_last) |=> (step_reg == 2'd0), "step not restarted after last word")

endmodule
